/* rtl/core/itrd_pkg.sv */
package itrd_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 16;
    localparam int DIGIT_W    = $clog2(MAX_RADIX);
    localparam int RADIX_W    = DIGIT_W + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int STEP_BITS  = 8;
    localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W      = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CHAR_W     = 8;
    localparam int TABLE_W    = 16 * CHAR_W;
    localparam int CFG_W      = 64;
    localparam int PADDR_W    = 5;
    localparam int BASE_W     = 5;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

    typedef enum logic [PADDR_W-4:0] {
        REG_BASE_SIZE,
        REG_CHARS_LOW,
        REG_CHARS_HIGH
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIGIT_W-1:0]    rem;
        logic [VALUE_BITS-1:0] quo;
    } div_res_t;

    function automatic logic [RADIX_W-1:0] radix_of(input logic [BASE_W-1:0] b);
        logic [RADIX_W-1:0] r;
        if (b < BASE_W'(2))
            r = RADIX_W'(2);
        else if (b > BASE_W'(MAX_RADIX))
            r = RADIX_W'(MAX_RADIX);
        else
            r = b[RADIX_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/core/itrd_ram.sv */
module itrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/itrd_div.sv */
module itrd_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [itrd_pkg::VALUE_BITS-1:0]    num,
    input  logic [itrd_pkg::RADIX_W-1:0]       radix,
    output itrd_pkg::div_res_t                 res
);
    import itrd_pkg::*;

    logic [DIV_W-1:0]      q_reg;
    logic [DIV_W-1:0]      q_next;
    logic [DIGIT_W-1:0]    r_reg;
    logic [DIGIT_W-1:0]    r_next;
    logic [STEP_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // eight restoring steps per cycle on the narrow remainder
    always_comb
    begin
        logic [RADIX_W-1:0] r_t;
        q_next = q_reg;
        r_t    = {1'b0, r_reg};
        for (int i = 0; i < STEP_BITS; i++)
        begin
            r_t    = {r_t[DIGIT_W-1:0], q_next[DIV_W-1]};
            q_next = {q_next[DIV_W-2:0], 1'b0};
            if (r_t >= radix)
            begin
                r_t       = r_t - radix;
                q_next[0] = 1'b1;
            end
        end
        r_next = r_t[DIGIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            r_reg    <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            q_reg    <= DIV_W'(num);
            r_reg    <= '0;
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            q_reg    <= q_next;
            r_reg    <= r_next;
            step_reg <= step_reg + STEP_CNT_W'(1);
            if (step_reg == STEP_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.rem  = r_reg;
    assign res.quo  = q_reg[VALUE_BITS-1:0];

endmodule

/* rtl/core/integer_to_radix_digits_top.sv */
// Converts one signed 32-bit value per input item into its text in the radix
// set by base_size (clamped to 2..16), one character per output item, most
// significant digit first, with a leading minus sign for negative values and
// last_char set on the final character. Each digit is one division in the
// divider (8 quotient bits per cycle), and its remainder is stored in the
// digit buffer RAM; then comes a fetch state, and the sign and digits leave
// at one per cycle, unless held by out_stall, from the buffer read port. The
// next item is taken once the last character is loaded into the output
// register.
module integer_to_radix_digits_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [itrd_pkg::PADDR_W-1:0]       paddr,
    input  logic [itrd_pkg::CFG_W-1:0]         pwdata,
    output logic [itrd_pkg::CFG_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [itrd_pkg::VALUE_BITS-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [itrd_pkg::CHAR_W-1:0]        out_char,
    output logic                               last_char
);
    import itrd_pkg::*;

    logic [BASE_W-1:0]     base_size_reg;
    logic [CFG_W-1:0]      chars_low_reg;
    logic [CFG_W-1:0]      chars_high_reg;
    reg_idx_t              reg_idx;
    logic                  cfg_we;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      rd_idx_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [VALUE_BITS-1:0] magnitude_reg;
    logic [VALUE_BITS-1:0] magnitude_next;

    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] mag_in;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_num;
    div_res_t              div_res;
    logic [RADIX_W-1:0]    radix;

    logic                  ram_we;
    logic [DIGIT_W-1:0]    rd_data;
    logic [TABLE_W-1:0]    char_table;
    logic [CHAR_W-1:0]     symbol;

    logic                  out_free;
    logic                  load_out;
    logic [CHAR_W-1:0]     load_char;
    logic                  load_last;
    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  last_char_reg;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg  <= BASE_RESET;
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_BASE_SIZE:  base_size_reg  <= pwdata[BASE_W-1:0];
                REG_CHARS_LOW:  chars_low_reg  <= pwdata;
                REG_CHARS_HIGH: chars_high_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BASE_SIZE:  prdata = CFG_W'(base_size_reg);
            REG_CHARS_LOW:  prdata = chars_low_reg;
            REG_CHARS_HIGH: prdata = chars_high_reg;
            default:        prdata = '0;
        endcase
    end

    assign radix      = radix_of(base_size_reg);
    assign value_u    = value;
    assign mag_in     = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign char_table = {chars_high_reg, chars_low_reg};
    assign symbol     = char_table[{rd_data, 3'b000} +: CHAR_W];
    assign div_num    = (state_reg == ST_IDLE) ? mag_in : div_res.quo;

    itrd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .radix (radix),
        .res   (div_res)
    );

    itrd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (div_res.rem),
        .raddr (rd_idx_next),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        neg_next       = neg_reg;
        magnitude_next = magnitude_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        load_out       = 1'b0;
        load_char      = symbol;
        load_last      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    magnitude_next = mag_in;
                    neg_next       = value_u[VALUE_BITS-1];
                    count_next     = '0;
                    div_start      = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (div_res.quo != '0)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = count_reg[IDX_W-1:0];
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = neg_reg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_char  = MINUS_CHAR;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    load_last = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            neg_reg       <= 1'b0;
            magnitude_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            neg_reg       <= neg_next;
            magnitude_reg <= magnitude_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            last_char_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
            out_char_reg  <= load_char;
            last_char_reg <= load_last;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_res.busy || div_res.done) |-> (state_reg == ST_DIV))
        else $error("divider active outside digit loop");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count overflow");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (CNT_W'(rd_idx_reg) < count_reg))
        else $error("read index beyond stored digits");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && load_last) |=> (state_reg == ST_IDLE))
        else $error("last character did not end the item");

    a_magnitude_zero_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH && magnitude_reg == '0) |-> (count_reg == CNT_W'(1)))
        else $error("zero must give one digit");

endmodule

/* sim/tb.sv */
module tb;

    import itrd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 48;

    class radix_text_board;
        logic [BASE_W-1:0] base_size;
        logic [63:0]       chars_low;
        logic [63:0]       chars_high;
        logic [CHAR_W:0]   char_q[$];
        int                errors;

        function new();
            base_size  = BASE_RESET;
            chars_low  = '0;
            chars_high = '0;
            errors     = 0;
        endfunction

        function logic [CHAR_W-1:0] symbol_of(logic [DIGIT_W-1:0] d);
            if (d < 8)
                return chars_low[8*d +: 8];
            return chars_high[8*(d-8) +: 8];
        endfunction

        function void note_value(logic signed [VALUE_BITS-1:0] v);
            logic [VALUE_BITS-1:0] mag;
            logic [VALUE_BITS-1:0] radix;
            logic [DIGIT_W-1:0]    digs[VALUE_BITS];
            int                    n;
            if (base_size < 2)
                radix = 2;
            else if (base_size > MAX_RADIX)
                radix = MAX_RADIX;
            else
                radix = VALUE_BITS'(base_size);
            mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
            n = 0;
            do
            begin
                digs[n] = DIGIT_W'(mag % radix);
                n++;
                mag = mag / radix;
            end
            while (mag != 0);
            if (v[VALUE_BITS-1])
                char_q.push_back({1'b0, MINUS_CHAR});
            for (int i = n - 1; i >= 0; i--)
                char_q.push_back({(i == 0), symbol_of(digs[i])});
        endfunction

        function void check_char(logic [CHAR_W-1:0] c, logic l);
            logic [CHAR_W:0] exp_item;
            if (char_q.size() == 0)
            begin
                $error("out_char: no item expected, got %h", c);
                errors++;
                return;
            end
            exp_item = char_q.pop_front();
            if (c !== exp_item[CHAR_W-1:0])
            begin
                $error("out_char: expected %h, actual %h", exp_item[CHAR_W-1:0], c);
                errors++;
            end
            if (l !== exp_item[CHAR_W])
            begin
                $error("last_char: expected %b, actual %b", exp_item[CHAR_W], l);
                errors++;
            end
        endfunction

        function int waiting();
            return char_q.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [PADDR_W-1:0]           paddr = '0;
    logic [CFG_W-1:0]             pwdata = '0;
    logic [CFG_W-1:0]             prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [CHAR_W-1:0]            out_char;
    logic                         last_char;

    int              idle_pct = 21;
    int              cycles = 0;
    radix_text_board board = new();

    integer_to_radix_digits_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_char(out_char, last_char);
        out_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("integer_to_radix_digits_top: mismatch");
            $finish;
        end
    end

    task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BASE_SIZE:  board.base_size  = data[BASE_W-1:0];
            REG_CHARS_LOW:  board.chars_low  = data;
            REG_CHARS_HIGH: board.chars_high = data;
            default: ;
        endcase
    endtask

    task automatic set_radix(input logic [BASE_W-1:0] b, input logic [63:0] lo,
                             input logic [63:0] hi);
        write_register(REG_BASE_SIZE, CFG_W'(b));
        write_register(REG_CHARS_LOW, lo);
        write_register(REG_CHARS_HIGH, hi);
    endtask

    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_value(v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1:
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    v = ~v + 1'b1;
            end
            2: v = $urandom_range(600) - 300;
            default:
            begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    localparam logic [63:0] HEX_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [63:0] HEX_HIGH = 64'h4645_4443_4241_3938;

    initial
    begin
        logic [BASE_W-1:0] phase_base[NUM_PHASES];
        logic [63:0]       lo;
        logic [63:0]       hi;
        phase_base = '{5'd10, 5'd0, 5'd1, 5'd17, 5'd31, 5'd16, 5'd3, 5'd2};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(1000000000);
        send_value(-999999999);
        send_value(9);
        drain();

        set_radix(5'd2, HEX_LOW, HEX_HIGH);
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(32'shAAAA_AAAA);
        send_value(32'sh5555_5555);
        drain();

        set_radix(5'd16, HEX_LOW, HEX_HIGH);
        send_value(32'sh8000_0000);
        send_value(32'shFEDC_BA98);
        send_value(32'sh0123_4567);
        send_value(15);
        send_value(16);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                1:
                begin
                    lo = HEX_LOW;
                    hi = HEX_HIGH;
                end
                2:
                begin
                    lo = '1;
                    hi = '0;
                end
                default:
                begin
                    lo = {8{8'h41}};
                    hi = {$urandom, $urandom};
                end
            endcase
            set_radix(phase_base[p], lo, hi);
            idle_pct = (p == 3) ? 0 : 21;
            repeat (PHASE_ITEMS) send_value(pick_value());
            drain();
        end

        set_radix(BASE_W'($urandom_range(31)), {$urandom, $urandom}, {$urandom, $urandom});
        repeat (16) send_value(pick_value());
        drain();
        repeat (20) @(posedge clk);

        if (board.errors == 0)
            $display("integer_to_radix_digits_top: match");
        else
            $display("integer_to_radix_digits_top: mismatch");
        $finish;
    end

endmodule
